@@ hw/rtl/cache_tag_hit_miss_model_macros.svh @@
// assertion macros shared by the cache tag model blocks
`ifndef CACHE_TAG_HIT_MISS_MODEL_MACROS_SVH
`define CACHE_TAG_HIT_MISS_MODEL_MACROS_SVH

// same-cycle implication, disabled in reset
`define CTHM_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("cthm check failed");

// next-cycle implication, disabled in reset
`define CTHM_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("cthm check failed");

`endif

@@ hw/rtl/cthm_pkg.sv @@
// shared constants and types for the cache tag hit/miss model
package cthm_pkg;

  // parameter defaults
  localparam int DEF_ADDR_BITS      = 16;
  localparam int DEF_MAX_INDEX_BITS = 10;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_ASSOC_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS  = 2'd2;

  localparam logic       RST_ASSOC_MODE  = 1'b0;
  localparam logic [3:0] RST_OFFSET_BITS = 4'd5;
  localparam logic [3:0] RST_INDEX_BITS  = 4'd8;

  // shift amounts: offset (up to 15) plus index (up to 15)
  localparam int SHAMT_W = 6;

  // hit and miss counters
  localparam int CNT_W = 32;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hw/rtl/cthm_front.sv @@
// front end: configuration registers, item intake and address split
module cthm_front #(
  parameter int ADDR_BITS      = cthm_pkg::DEF_ADDR_BITS,
  parameter int MAX_INDEX_BITS = cthm_pkg::DEF_MAX_INDEX_BITS,
  parameter int ENTRY_W        = 1 + MAX_INDEX_BITS + ADDR_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cthm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cthm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ADDR_BITS-1:0]               address,
  input  cthm_pkg::q_status_t                q_status,
  input  logic                               clearing,
  output logic                               push,
  output logic [ENTRY_W-1:0]                 push_data
);

  logic       assoc_mode;
  logic [3:0] offset_bits;
  logic [3:0] index_bits;

  logic [cthm_pkg::SHAMT_W-1:0] ib_lim;
  logic [cthm_pkg::SHAMT_W-1:0] ib;
  logic [cthm_pkg::SHAMT_W-1:0] tag_shift;
  logic [ADDR_BITS-1:0]         shifted;
  logic [MAX_INDEX_BITS-1:0]    idx;
  logic [ADDR_BITS-1:0]         tag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      assoc_mode  <= cthm_pkg::RST_ASSOC_MODE;
      offset_bits <= cthm_pkg::RST_OFFSET_BITS;
      index_bits  <= cthm_pkg::RST_INDEX_BITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cthm_pkg::REG_ASSOC_MODE:  assoc_mode  <= cfg_data[0];
        cthm_pkg::REG_OFFSET_BITS: offset_bits <= cfg_data[3:0];
        cthm_pkg::REG_INDEX_BITS:  index_bits  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // index width clamps to the store size; two-way drops one bit
  always_comb begin
    if (cthm_pkg::SHAMT_W'(index_bits) > cthm_pkg::SHAMT_W'(MAX_INDEX_BITS)) begin
      ib_lim = cthm_pkg::SHAMT_W'(MAX_INDEX_BITS);
    end else begin
      ib_lim = cthm_pkg::SHAMT_W'(index_bits);
    end
    if (assoc_mode && ib_lim != '0) begin
      ib = ib_lim - cthm_pkg::SHAMT_W'(1);
    end else if (assoc_mode) begin
      ib = '0;
    end else begin
      ib = ib_lim;
    end
    shifted   = address >> offset_bits;
    idx       = MAX_INDEX_BITS'(shifted) & ~({MAX_INDEX_BITS{1'b1}} << ib);
    tag_shift = cthm_pkg::SHAMT_W'(offset_bits) + ib;
    tag       = address >> tag_shift;
  end

  assign in_ready  = !clearing && !q_status.full;
  assign push      = in_valid && in_ready;
  assign push_data = {assoc_mode, idx, tag};

endmodule

@@ hw/rtl/cthm_queue.sv @@
// short queue of split addresses between front and back
`include "cache_tag_hit_miss_model_macros.svh"

module cthm_queue #(
  parameter int WIDTH = 27
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    head,
  output cthm_pkg::q_status_t status
);

  localparam int DEPTH = cthm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  `CTHM_ASSERT_IMPL(a_no_overflow, clk, rst, push, !status.full)
  `CTHM_ASSERT_IMPL(a_no_underflow, clk, rst, pop, !status.empty)

endmodule

@@ hw/rtl/cthm_back.sv @@
// back end: tag stores, lookup and fill, counters and result register
`include "cache_tag_hit_miss_model_macros.svh"

module cthm_back #(
  parameter int ADDR_BITS      = cthm_pkg::DEF_ADDR_BITS,
  parameter int MAX_INDEX_BITS = cthm_pkg::DEF_MAX_INDEX_BITS,
  parameter int ENTRY_W        = 1 + MAX_INDEX_BITS + ADDR_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ENTRY_W-1:0]           head,
  input  cthm_pkg::q_status_t          q_status,
  output logic                         pop,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [cthm_pkg::CNT_W-1:0]   hit_total,
  output logic [cthm_pkg::CNT_W-1:0]   miss_total
);

  localparam int LINES = 2 ** MAX_INDEX_BITS;
  localparam int SET_W = MAX_INDEX_BITS - 1;
  localparam int SETS  = 2 ** SET_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP
  } state_t;

  state_t state;

  logic [MAX_INDEX_BITS-1:0] clr_cnt;
  logic                      cur_assoc;
  logic [MAX_INDEX_BITS-1:0] cur_idx;
  logic [ADDR_BITS-1:0]      cur_tag;

  // way 0 entry: {valid, tag}; way 1 entry: {toggle, valid, tag}
  logic [ADDR_BITS:0]   mem0 [LINES];
  logic [ADDR_BITS+1:0] mem1 [SETS];
  logic [ADDR_BITS:0]   rd0;
  logic [ADDR_BITS+1:0] rd1;

  logic                      we0;
  logic [MAX_INDEX_BITS-1:0] wa0;
  logic [ADDR_BITS:0]        wd0;
  logic                      we1;
  logic [SET_W-1:0]          wa1;
  logic [ADDR_BITS+1:0]      wd1;

  logic hit0;
  logic hit1;
  logic is_hit;
  logic toggle;
  logic out_free;
  logic resolve;

  assign hit0     = rd0[ADDR_BITS] && (rd0[ADDR_BITS-1:0] == cur_tag);
  assign hit1     = cur_assoc && rd1[ADDR_BITS] && (rd1[ADDR_BITS-1:0] == cur_tag);
  assign is_hit   = hit0 || hit1;
  assign toggle   = rd1[ADDR_BITS+1];
  assign out_free = !out_valid || out_ready;
  assign resolve  = (state == ST_CMP) && out_free;
  assign pop      = (state == ST_IDLE) && !q_status.empty;
  assign clearing = (state == ST_CLEAR);

  always_comb begin
    we0 = 1'b0;
    wa0 = cur_idx;
    wd0 = {1'b1, cur_tag};
    we1 = 1'b0;
    wa1 = cur_idx[SET_W-1:0];
    wd1 = rd1;
    if (state == ST_CLEAR) begin
      we0 = 1'b1;
      wa0 = clr_cnt;
      wd0 = '0;
      we1 = 1'b1;
      wa1 = clr_cnt[SET_W-1:0];
      wd1 = '0;
    end else if (resolve && !is_hit) begin
      if (!cur_assoc) begin
        we0 = 1'b1;
      end else begin
        we1 = 1'b1;
        if (!toggle) begin
          // fill way 0, keep way 1, flip toggle
          we0 = 1'b1;
          wd1 = {1'b1, rd1[ADDR_BITS:0]};
        end else begin
          wd1 = {1'b0, 1'b1, cur_tag};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wa0] <= wd0;
    end
    rd0 <= mem0[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wa1] <= wd1;
    end
    rd1 <= mem1[cur_idx[SET_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
      hit_total  <= '0;
      miss_total <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + MAX_INDEX_BITS'(1);
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            cur_assoc <= head[ENTRY_W-1];
            cur_idx   <= head[ADDR_BITS +: MAX_INDEX_BITS];
            cur_tag   <= head[ADDR_BITS-1:0];
            state     <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            hit       <= is_hit;
            if (is_hit && hit_total != '1) begin
              hit_total <= hit_total + cthm_pkg::CNT_W'(1);
            end
            if (!is_hit && miss_total != '1) begin
              miss_total <= miss_total + cthm_pkg::CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `CTHM_ASSERT_NEXT(a_result_after_resolve, clk, rst, resolve, out_valid)
  `CTHM_ASSERT_NEXT(a_counts_hold, clk, rst, state != ST_CMP, (hit_total == $past(hit_total)) && (miss_total == $past(miss_total)))
  `CTHM_ASSERT_IMPL(a_no_result_in_clear, clk, rst, state == ST_CLEAR, !out_valid)

endmodule

@@ hw/rtl/cache_tag_hit_miss_model.sv @@
// top level of the cache tag hit/miss model
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in        in         in_valid / in_ready    address
//   out       out        out_valid / out_ready  hit, hit_total, miss_total
//
// steps: the back end works on one item at a time (queue pop, tag store read,
//   compare and fill) and pops the next item only after the compare step ends
// the front accepts an item whenever the 2-entry queue has room and no clearing pass runs
// reset: a clearing pass over all 2**MAX_INDEX_BITS lines (1024 by default)
//   wipes valid bits and toggles; in_ready stays low meanwhile, cfg is taken
// stalls: a held result keeps the back end in its compare step, the queue
//   fills and then in_ready drops
module cache_tag_hit_miss_model #(
  parameter int ADDR_BITS      = cthm_pkg::DEF_ADDR_BITS,
  parameter int MAX_INDEX_BITS = cthm_pkg::DEF_MAX_INDEX_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cthm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cthm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ADDR_BITS-1:0]               address,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               hit,
  output logic [cthm_pkg::CNT_W-1:0]         hit_total,
  output logic [cthm_pkg::CNT_W-1:0]         miss_total
);

  // queue entry: {assoc mode, line or set index, tag}
  localparam int ENTRY_W = 1 + MAX_INDEX_BITS + ADDR_BITS;

  cthm_pkg::q_status_t q_status;
  logic                push;
  logic [ENTRY_W-1:0]  push_data;
  logic                pop;
  logic [ENTRY_W-1:0]  head;
  logic                clearing;

  // front: config registers and address split
  cthm_front #(
    .ADDR_BITS      (ADDR_BITS),
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .ENTRY_W        (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .address   (address),
    .q_status  (q_status),
    .clearing  (clearing),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  cthm_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // back: tag lookup, replacement and counters
  cthm_back #(
    .ADDR_BITS      (ADDR_BITS),
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .ENTRY_W        (ENTRY_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

endmodule
